/* rtl/escaped_frame_receiver_macros.svh */
// Assertion helpers for the escaped frame receiver.
`ifndef ESCAPED_FRAME_RECEIVER_MACROS_SVH
`define ESCAPED_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EFR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define EFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/efr_pkg.sv */
`default_nettype none
package efr_pkg;

  localparam logic [7:0] ESC_BYTE      = 8'hDB;
  localparam logic [7:0] ESC_FOR_ESC   = 8'hDD;
  localparam logic [7:0] ESC_FOR_DELIM = 8'hDE;
  localparam logic [7:0] DELIM_RESET   = 8'h12;

  typedef enum logic [1:0] {
    PHASE_IDLE  = 2'd0,
    PHASE_FRAME = 2'd1,
    PHASE_ESC   = 2'd2
  } phase_e;

  typedef struct packed {
    logic       frame_end;
    logic [7:0] data_byte;
    logic [7:0] frame_length;
    logic       bad_escape;
    logic       overflow;
  } result_t;

endpackage
`default_nettype wire

/* rtl/efr_decode.sv */
`default_nettype none
module efr_decode #(
  parameter int MAX_LEN = 255
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic [7:0]      rx_byte_i,
  output logic                 in_stall_o,
  input  wire logic [7:0]      delimiter_i,
  output logic                 res_valid_o,
  output efr_pkg::result_t     res_o,
  input  wire logic            res_stall_i
);
  import efr_pkg::*;

  localparam logic [8:0] MaxLenW = 9'(MAX_LEN);

  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  phase_e     phase_q, phase_d;
  logic [7:0] count_q, count_d;
  logic       hit_delim, hit_esc, emit, advance;
  logic [8:0] cnt_inc;
  logic       wrap;

  assign hit_delim = (s1_byte_q == delimiter_i);
  assign hit_esc   = (s1_byte_q == ESC_BYTE);
  assign cnt_inc   = {1'b0, count_q} + 9'd1;
  assign wrap      = (cnt_inc >= MaxLenW);

  // a beat that produces nothing never waits on the output side
  assign res_valid_o = s1_valid_q && emit;
  assign advance     = s1_valid_q && (!emit || !res_stall_i);
  assign in_stall_o  = s1_valid_q && !advance;
  assign s1_valid_d  = in_stall_o ? s1_valid_q : in_valid_i;

  always_comb begin
    phase_d = phase_q;
    if (advance) begin
      unique case (phase_q)
        PHASE_IDLE: begin
          if (hit_delim) phase_d = PHASE_FRAME;
        end
        PHASE_FRAME, PHASE_ESC: begin
          if (hit_delim)    phase_d = PHASE_IDLE;
          else if (hit_esc) phase_d = PHASE_ESC;
          else              phase_d = PHASE_FRAME;
        end
        default: begin
          phase_d = hit_delim ? PHASE_FRAME : PHASE_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    emit    = 1'b0;
    res_o   = '0;
    count_d = count_q;
    if (phase_q == PHASE_FRAME || phase_q == PHASE_ESC) begin
      if (hit_delim) begin
        emit               = 1'b1;
        res_o.frame_end    = 1'b1;
        res_o.frame_length = count_q;
        count_d            = '0;
      end else if (!hit_esc) begin
        emit               = 1'b1;
        res_o.data_byte    = s1_byte_q;
        if (phase_q == PHASE_ESC) begin
          if (s1_byte_q == ESC_FOR_ESC)        res_o.data_byte  = ESC_BYTE;
          else if (s1_byte_q == ESC_FOR_DELIM) res_o.data_byte  = delimiter_i;
          else                                 res_o.bad_escape = 1'b1;
        end
        res_o.overflow     = wrap;
        res_o.frame_length = wrap ? 8'd0 : cnt_inc[7:0];
        count_d            = res_o.frame_length;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      phase_q    <= PHASE_IDLE;
      count_q    <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      phase_q    <= phase_d;
      if (advance) count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) s1_byte_q <= rx_byte_i;
  end

endmodule
`default_nettype wire

/* rtl/efr_out_reg.sv */
`default_nettype none
module efr_out_reg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              res_valid_i,
  input  wire efr_pkg::result_t  res_i,
  output logic                   res_stall_o,
  output logic                   out_valid_o,
  output efr_pkg::result_t       out_o,
  input  wire logic              out_stall_i
);
  import efr_pkg::*;

  logic    valid_q, valid_d;
  result_t data_q;

  assign res_stall_o = valid_q && out_stall_i;
  assign valid_d     = res_stall_o ? valid_q : res_valid_i;
  assign out_valid_o = valid_q;
  assign out_o       = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i && !res_stall_o) data_q <= res_i;
  end

endmodule
`default_nettype wire

/* rtl/escaped_frame_receiver.sv */
// Channel   Direction  Handshake            Beat contents
// in        input      in_valid / in_stall  rx_byte
// out       output     out_valid/out_stall  frame_end, data_byte, frame_length,
//                                           bad_escape, overflow
// cfg       input      cfg_valid/cfg_ready  delimiter (cfg_data)
//
// One byte per cycle while the output is not stalled; an accepted byte reaches
// the output through the input register, then the result register.
// Reset clears the frame phase, the length count and the pipeline valids and
// loads the delimiter with 0x12.
// A stalled output backs up into the input register; bytes that give no
// result drain even while the output is stalled.
`default_nettype none
module escaped_frame_receiver #(
  parameter int MAX_LEN = 255
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            frame_end_o,
  output logic [7:0]      data_byte_o,
  output logic [7:0]      frame_length_o,
  output logic            bad_escape_o,
  output logic            overflow_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [7:0] cfg_data_i
);
  import efr_pkg::*;

  logic [7:0] delimiter_q;
  logic       res_valid, res_stall;
  result_t    res, out_res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delimiter_q <= DELIM_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      delimiter_q <= cfg_data_i;
    end
  end

  efr_decode #(
    .MAX_LEN(MAX_LEN)
  ) u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .rx_byte_i  (rx_byte_i),
    .in_stall_o (in_stall_o),
    .delimiter_i(delimiter_q),
    .res_valid_o(res_valid),
    .res_o      (res),
    .res_stall_i(res_stall)
  );

  efr_out_reg u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_valid_i(res_valid),
    .res_i      (res),
    .res_stall_o(res_stall),
    .out_valid_o(out_valid_o),
    .out_o      (out_res),
    .out_stall_i(out_stall_i)
  );

  assign frame_end_o    = out_res.frame_end;
  assign data_byte_o    = out_res.data_byte;
  assign frame_length_o = out_res.frame_length;
  assign bad_escape_o   = out_res.bad_escape;
  assign overflow_o     = out_res.overflow;

`include "escaped_frame_receiver_macros.svh"

  `EFR_ASSERT_NOW(a_end_clean, clk_i, rst_ni,
    out_valid_o && frame_end_o,
    data_byte_o == 8'd0 && !bad_escape_o && !overflow_o,
    "frame end beat carries payload flags")
  `EFR_ASSERT_NOW(a_wrap_zero, clk_i, rst_ni,
    out_valid_o && !frame_end_o && overflow_o,
    frame_length_o == 8'd0,
    "overflow beat with nonzero length")
  `EFR_ASSERT_NOW(a_len_nonzero, clk_i, rst_ni,
    out_valid_o && !frame_end_o && !overflow_o,
    frame_length_o != 8'd0,
    "payload beat with zero length")
  `EFR_ASSERT_NOW(a_in_drain, clk_i, rst_ni,
    !out_valid_o,
    !in_stall_o,
    "input stalled behind empty output")
  `EFR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni,
    out_valid_o && out_stall_i,
    out_valid_o && $stable(out_res),
    "stalled output beat changed")

endmodule
`default_nettype wire
